// File: src/ccirc_pkg.sv
// Shared types and constants for the circumcircle pipeline.
package ccirc_pkg;

   // Field widths of the transactions
   localparam int COORD_BITS    = 16;
   localparam int FRAC_BITS_DEF = 8;
   localparam int OUT_BITS      = 40;
   localparam int RAD_BITS      = 39;

   // Exponent of the quotient magnitude at which the centre offset counts as unbounded
   localparam int HUGE_EXP    = 50;
   // Exponent of the centre offset magnitude at which the radius is forced to its limit
   localparam int RAD_LIM_EXP = 40;

   localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
   localparam logic [RAD_BITS-1:0] RAD_MAX = {RAD_BITS{1'b1}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic signed [COORD_BITS-1:0] third_x;
      logic signed [COORD_BITS-1:0] third_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] centre_x;
      logic signed [OUT_BITS-1:0] centre_y;
      logic [RAD_BITS-1:0]        radius;
      logic                       collinear;
      logic                       saturated;
   } rsp_type;

endpackage

// File: src/ccirc_div.sv
// Pipelined restoring divider: two numerators over one divisor, one quotient bit per stage.
module ccirc_div #(
   parameter int NUM_W  = 58,
   parameter int DEN_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num_x,
   input  logic [NUM_W-1:0]  in_num_y,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo_x,
   output logic [NUM_W-1:0]  out_quo_y,
   output logic              out_rem_nz_x,
   output logic              out_rem_nz_y,
   output logic [SIDE_W-1:0] out_side
);

   // Per-stage registers: numerator bits shift out on top, quotient bits shift in below
   logic              v_ff    [NUM_W];
   logic [NUM_W-1:0]  wx_ff   [NUM_W];
   logic [NUM_W-1:0]  wy_ff   [NUM_W];
   logic [DEN_W-1:0]  rx_ff   [NUM_W];
   logic [DEN_W-1:0]  ry_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              v_cur;
      logic [NUM_W-1:0]  wx_cur, wy_cur;
      logic [DEN_W-1:0]  rx_cur, ry_cur, den_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [DEN_W:0]    tx, ty, dx, dy;
      logic              gex, gey;
      logic [DEN_W-1:0]  rx_in, ry_in;
      logic [NUM_W-1:0]  wx_in, wy_in;

      if (k == 0) begin : g_first
         assign v_cur    = in_valid;
         assign wx_cur   = in_num_x;
         assign wy_cur   = in_num_y;
         assign rx_cur   = '0;
         assign ry_cur   = '0;
         assign den_cur  = in_den;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = v_ff[k-1];
         assign wx_cur   = wx_ff[k-1];
         assign wy_cur   = wy_ff[k-1];
         assign rx_cur   = rx_ff[k-1];
         assign ry_cur   = ry_ff[k-1];
         assign den_cur  = den_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // Trial subtract of the divisor from the partial remainder
      always_comb begin
         tx    = {rx_cur, wx_cur[NUM_W-1]};
         ty    = {ry_cur, wy_cur[NUM_W-1]};
         dx    = tx - {1'b0, den_cur};
         dy    = ty - {1'b0, den_cur};
         gex   = tx >= {1'b0, den_cur};
         gey   = ty >= {1'b0, den_cur};
         rx_in = gex ? dx[DEN_W-1:0] : tx[DEN_W-1:0];
         ry_in = gey ? dy[DEN_W-1:0] : ty[DEN_W-1:0];
         wx_in = {wx_cur[NUM_W-2:0], gex};
         wy_in = {wy_cur[NUM_W-2:0], gey};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_cur;
         end
         if (adv) begin
            wx_ff[k]   <= wx_in;
            wy_ff[k]   <= wy_in;
            rx_ff[k]   <= rx_in;
            ry_ff[k]   <= ry_in;
            den_ff[k]  <= den_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid    = v_ff[NUM_W-1];
   assign out_quo_x    = wx_ff[NUM_W-1];
   assign out_quo_y    = wy_ff[NUM_W-1];
   assign out_rem_nz_x = |rx_ff[NUM_W-1];
   assign out_rem_nz_y = |ry_ff[NUM_W-1];
   assign out_side     = side_ff[NUM_W-1];

endmodule

// File: src/ccirc_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module ccirc_sqrt #(
   parameter int VAL_W  = 82,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [VAL_W-1:0]     in_value,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [VAL_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int RT_W = VAL_W / 2;

   logic              v_ff    [RT_W];
   logic [VAL_W-1:0]  val_ff  [RT_W];
   logic [RT_W:0]     rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic              v_cur;
      logic [VAL_W-1:0]  val_cur;
      logic [RT_W:0]     rem_cur;
      logic [RT_W-1:0]   root_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [RT_W+2:0]   cur, trial, diff;
      logic              ge;
      logic [RT_W:0]     rem_in;
      logic [RT_W-1:0]   root_in;
      logic [VAL_W-1:0]  val_in;

      if (k == 0) begin : g_first
         assign v_cur    = in_valid;
         assign val_cur  = in_value;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = v_ff[k-1];
         assign val_cur  = val_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // Bring down two bits, try subtracting 4*root+1
      always_comb begin
         cur     = {rem_cur, val_cur[VAL_W-1 -: 2]};
         trial   = {1'b0, root_cur, 2'b01};
         diff    = cur - trial;
         ge      = cur >= trial;
         rem_in  = ge ? diff[RT_W:0] : cur[RT_W:0];
         root_in = {root_cur[RT_W-2:0], ge};
         val_in  = val_cur << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_cur;
         end
         if (adv) begin
            val_ff[k]  <= val_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = v_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

// File: src/circumcircle_of_three_points.sv
// Circumscribed circle of three points: fully pipelined top level.
//
// Request channel (req_valid / req_stall / req_data): one point triple per
// transaction. Response channel (rsp_valid / rsp_stall / rsp_data): one
// circle per transaction, in request order.
// Throughput: one transaction per cycle; a new triple is taken every cycle
// the response register is free or being emptied.
// Pipeline stages: seven setup stages, one stage per quotient bit in the
// divider (3*16 + 2 + FRAC_BITS), five stages of fix-up and squaring,
// 41 stages of the square root, and the response register.
// Collinear or repeated points give the circle on the farthest pair and
// set collinear; a clipped centre or radius sets saturated.
// Reset empties every stage; no response is presented until new requests
// pass through. While rsp_valid is high and rsp_stall is asserted the whole
// pipeline holds and req_stall is raised; nothing is dropped or repeated.
module circumcircle_of_three_points #(
   parameter int FRAC_BITS = ccirc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ccirc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ccirc_pkg::rsp_type rsp_data
);
   import ccirc_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int DLW    = C + 1;              // coordinate difference
   localparam int SQW    = 2 * C;              // square of a difference
   localparam int SUMW   = 2 * C + 1;          // squared length
   localparam int XW     = 2 * DLW;            // cross product, signed
   localparam int DVW    = 2 * C + 2;          // |2 * cross|
   localparam int NXW    = 3 * C + 3;          // centre numerator, signed
   localparam int NW     = 3 * C + 2 + FRAC_BITS;
   localparam int QEW    = (NW > HUGE_EXP) ? NW : HUGE_EXP + 1;
   localparam int QSW    = HUGE_EXP + 2;
   localparam int CW     = ((C + FRAC_BITS + 1 > QSW) ? C + FRAC_BITS + 1 : QSW) + 1;
   localparam int HW     = RAD_LIM_EXP / 2;
   localparam int SV_RAW = (2 * RAD_LIM_EXP + 1 > 2 * C + 2 * FRAC_BITS + 1) ?
                           2 * RAD_LIM_EXP + 1 : 2 * C + 2 * FRAC_BITS + 1;
   localparam int SVW    = SV_RAW + (SV_RAW % 2);
   localparam int RTW    = SVW / 2;

   localparam logic [QSW-1:0] HUGE_POS = QSW'(1) << HUGE_EXP;
   localparam logic [QSW-1:0] HUGE_NEG = ~HUGE_POS + QSW'(1);
   localparam logic [RTW-1:0] RAD_LIM  = RTW'(1) << RAD_LIM_EXP;

   typedef struct packed {
      logic                  col;
      logic signed [C-1:0]   x1;
      logic signed [C-1:0]   y1;
      logic signed [DLW-1:0] ccx;
      logic signed [DLW-1:0] ccy;
      logic [SUMW-1:0]       dd;
      logic                  negx;
      logic                  negy;
   } side_a_type;

   typedef struct packed {
      logic                 col;
      logic                 big;
      logic signed [CW-1:0] cenx;
      logic signed [CW-1:0] ceny;
   } side_b_type;

   localparam int SA_W = $bits(side_a_type);
   localparam int SB_W = $bits(side_b_type);

   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // Whole pipeline moves unless the response register is full and stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: capture the request
   logic    s1_v_ff;
   req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
      if (adv) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: differences and pair sums
   logic                  s2_v_ff;
   logic signed [C-1:0]   s2_x1_ff, s2_y1_ff;
   logic signed [DLW-1:0] s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff, s2_ex_ff, s2_ey_ff;
   logic signed [DLW-1:0] s2_sx12_ff, s2_sy12_ff, s2_sx13_ff, s2_sy13_ff;
   logic signed [DLW-1:0] s2_sx23_ff, s2_sy23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s2_x1_ff   <= s1_req_ff.first_x;
         s2_y1_ff   <= s1_req_ff.first_y;
         s2_ax_ff   <= DLW'(s1_req_ff.second_x) - DLW'(s1_req_ff.first_x);
         s2_ay_ff   <= DLW'(s1_req_ff.second_y) - DLW'(s1_req_ff.first_y);
         s2_bx_ff   <= DLW'(s1_req_ff.third_x) - DLW'(s1_req_ff.first_x);
         s2_by_ff   <= DLW'(s1_req_ff.third_y) - DLW'(s1_req_ff.first_y);
         s2_ex_ff   <= DLW'(s1_req_ff.third_x) - DLW'(s1_req_ff.second_x);
         s2_ey_ff   <= DLW'(s1_req_ff.third_y) - DLW'(s1_req_ff.second_y);
         s2_sx12_ff <= DLW'(s1_req_ff.first_x) + DLW'(s1_req_ff.second_x);
         s2_sy12_ff <= DLW'(s1_req_ff.first_y) + DLW'(s1_req_ff.second_y);
         s2_sx13_ff <= DLW'(s1_req_ff.first_x) + DLW'(s1_req_ff.third_x);
         s2_sy13_ff <= DLW'(s1_req_ff.first_y) + DLW'(s1_req_ff.third_y);
         s2_sx23_ff <= DLW'(s1_req_ff.second_x) + DLW'(s1_req_ff.third_x);
         s2_sy23_ff <= DLW'(s1_req_ff.second_y) + DLW'(s1_req_ff.third_y);
      end
   end

   // Stage 3: cross terms and squares
   logic signed [XW-1:0] s3_pab_in, s3_pba_in;
   logic signed [XW-1:0] s3_qax, s3_qay, s3_qbx, s3_qby, s3_qex, s3_qey;

   always_comb begin
      s3_pab_in = s2_ax_ff * s2_by_ff;
      s3_pba_in = s2_ay_ff * s2_bx_ff;
      s3_qax    = s2_ax_ff * s2_ax_ff;
      s3_qay    = s2_ay_ff * s2_ay_ff;
      s3_qbx    = s2_bx_ff * s2_bx_ff;
      s3_qby    = s2_by_ff * s2_by_ff;
      s3_qex    = s2_ex_ff * s2_ex_ff;
      s3_qey    = s2_ey_ff * s2_ey_ff;
   end

   logic                  s3_v_ff;
   logic signed [XW-1:0]  s3_pab_ff, s3_pba_ff;
   logic [SQW-1:0]        s3_qax_ff, s3_qay_ff, s3_qbx_ff, s3_qby_ff, s3_qex_ff, s3_qey_ff;
   logic signed [C-1:0]   s3_x1_ff, s3_y1_ff;
   logic signed [DLW-1:0] s3_ax_ff, s3_ay_ff, s3_bx_ff, s3_by_ff;
   logic signed [DLW-1:0] s3_sx12_ff, s3_sy12_ff, s3_sx13_ff, s3_sy13_ff;
   logic signed [DLW-1:0] s3_sx23_ff, s3_sy23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
      if (adv) begin
         s3_pab_ff  <= s3_pab_in;
         s3_pba_ff  <= s3_pba_in;
         s3_qax_ff  <= s3_qax[SQW-1:0];
         s3_qay_ff  <= s3_qay[SQW-1:0];
         s3_qbx_ff  <= s3_qbx[SQW-1:0];
         s3_qby_ff  <= s3_qby[SQW-1:0];
         s3_qex_ff  <= s3_qex[SQW-1:0];
         s3_qey_ff  <= s3_qey[SQW-1:0];
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         s3_ax_ff   <= s2_ax_ff;
         s3_ay_ff   <= s2_ay_ff;
         s3_bx_ff   <= s2_bx_ff;
         s3_by_ff   <= s2_by_ff;
         s3_sx12_ff <= s2_sx12_ff;
         s3_sy12_ff <= s2_sy12_ff;
         s3_sx13_ff <= s2_sx13_ff;
         s3_sy13_ff <= s2_sy13_ff;
         s3_sx23_ff <= s2_sx23_ff;
         s3_sy23_ff <= s2_sy23_ff;
      end
   end

   // Stage 4: cross product and squared lengths
   logic                  s4_v_ff;
   logic signed [XW-1:0]  s4_cross_ff;
   logic [SUMW-1:0]       s4_a2_ff, s4_b2_ff, s4_d23_ff;
   logic signed [C-1:0]   s4_x1_ff, s4_y1_ff;
   logic signed [DLW-1:0] s4_ax_ff, s4_ay_ff, s4_bx_ff, s4_by_ff;
   logic signed [DLW-1:0] s4_sx12_ff, s4_sy12_ff, s4_sx13_ff, s4_sy13_ff;
   logic signed [DLW-1:0] s4_sx23_ff, s4_sy23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
      if (adv) begin
         s4_cross_ff <= s3_pab_ff - s3_pba_ff;
         s4_a2_ff    <= SUMW'(s3_qax_ff) + SUMW'(s3_qay_ff);
         s4_b2_ff    <= SUMW'(s3_qbx_ff) + SUMW'(s3_qby_ff);
         s4_d23_ff   <= SUMW'(s3_qex_ff) + SUMW'(s3_qey_ff);
         s4_x1_ff    <= s3_x1_ff;
         s4_y1_ff    <= s3_y1_ff;
         s4_ax_ff    <= s3_ax_ff;
         s4_ay_ff    <= s3_ay_ff;
         s4_bx_ff    <= s3_bx_ff;
         s4_by_ff    <= s3_by_ff;
         s4_sx12_ff  <= s3_sx12_ff;
         s4_sy12_ff  <= s3_sy12_ff;
         s4_sx13_ff  <= s3_sx13_ff;
         s4_sy13_ff  <= s3_sy13_ff;
         s4_sx23_ff  <= s3_sx23_ff;
         s4_sy23_ff  <= s3_sy23_ff;
      end
   end

   // Stage 5: numerator products, |d|, farthest pair for the collinear case
   logic signed [NXW-1:0] s5_p1_in, s5_p2_in, s5_p3_in, s5_p4_in;
   logic signed [XW-1:0]  s5_abs_cross;
   logic                  s5_sel12, s5_sel13;
   side_a_type            s5_side_in;

   always_comb begin
      s5_p1_in     = s4_by_ff * $signed({1'b0, s4_a2_ff});
      s5_p2_in     = s4_ay_ff * $signed({1'b0, s4_b2_ff});
      s5_p3_in     = s4_ax_ff * $signed({1'b0, s4_b2_ff});
      s5_p4_in     = s4_bx_ff * $signed({1'b0, s4_a2_ff});
      s5_abs_cross = s4_cross_ff[XW-1] ? -s4_cross_ff : s4_cross_ff;
      s5_sel12     = (s4_a2_ff >= s4_b2_ff) && (s4_a2_ff >= s4_d23_ff);
      s5_sel13     = !s5_sel12 && (s4_b2_ff >= s4_d23_ff);
      s5_side_in.col  = (s4_cross_ff == '0);
      s5_side_in.x1   = s4_x1_ff;
      s5_side_in.y1   = s4_y1_ff;
      s5_side_in.negx = 1'b0;
      s5_side_in.negy = 1'b0;
      if (s5_sel12) begin
         s5_side_in.ccx = s4_sx12_ff;
         s5_side_in.ccy = s4_sy12_ff;
         s5_side_in.dd  = s4_a2_ff;
      end else if (s5_sel13) begin
         s5_side_in.ccx = s4_sx13_ff;
         s5_side_in.ccy = s4_sy13_ff;
         s5_side_in.dd  = s4_b2_ff;
      end else begin
         s5_side_in.ccx = s4_sx23_ff;
         s5_side_in.ccy = s4_sy23_ff;
         s5_side_in.dd  = s4_d23_ff;
      end
   end

   logic                  s5_v_ff;
   logic signed [NXW-1:0] s5_p1_ff, s5_p2_ff, s5_p3_ff, s5_p4_ff;
   logic                  s5_dneg_ff;
   logic [DVW-1:0]        s5_dmag_ff;
   side_a_type            s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
      if (adv) begin
         s5_p1_ff   <= s5_p1_in;
         s5_p2_ff   <= s5_p2_in;
         s5_p3_ff   <= s5_p3_in;
         s5_p4_ff   <= s5_p4_in;
         s5_dneg_ff <= s4_cross_ff[XW-1];
         s5_dmag_ff <= {s5_abs_cross[XW-2:0], 1'b0};
         s5_side_ff <= s5_side_in;
      end
   end

   // Stage 6: centre numerators
   logic                  s6_v_ff;
   logic signed [NXW-1:0] s6_nx_ff, s6_ny_ff;
   logic                  s6_dneg_ff;
   logic [DVW-1:0]        s6_dmag_ff;
   side_a_type            s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
      if (adv) begin
         s6_nx_ff   <= s5_p1_ff - s5_p2_ff;
         s6_ny_ff   <= s5_p3_ff - s5_p4_ff;
         s6_dneg_ff <= s5_dneg_ff;
         s6_dmag_ff <= s5_dmag_ff;
         s6_side_ff <= s5_side_ff;
      end
   end

   // Stage 7: sign and scaled magnitude for the divider
   logic signed [NXW-1:0] s7_absx, s7_absy;
   side_a_type            s7_side_in;

   always_comb begin
      s7_absx         = s6_nx_ff[NXW-1] ? -s6_nx_ff : s6_nx_ff;
      s7_absy         = s6_ny_ff[NXW-1] ? -s6_ny_ff : s6_ny_ff;
      s7_side_in      = s6_side_ff;
      s7_side_in.negx = s6_nx_ff[NXW-1] ^ s6_dneg_ff;
      s7_side_in.negy = s6_ny_ff[NXW-1] ^ s6_dneg_ff;
   end

   logic           s7_v_ff;
   logic [NW-1:0]  s7_numx_ff, s7_numy_ff;
   logic [DVW-1:0] s7_dmag_ff;
   side_a_type     s7_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
      if (adv) begin
         s7_numx_ff <= NW'(s7_absx[NXW-2:0]) << FRAC_BITS;
         s7_numy_ff <= NW'(s7_absy[NXW-2:0]) << FRAC_BITS;
         s7_dmag_ff <= s6_dmag_ff;
         s7_side_ff <= s7_side_in;
      end
   end

   // Divider
   logic            dv_v;
   logic [NW-1:0]   dv_qx, dv_qy;
   logic            dv_rnzx, dv_rnzy;
   logic [SA_W-1:0] dv_side;
   side_a_type      dv_sa;

   ccirc_div #(
      .NUM_W  (NW),
      .DEN_W  (DVW),
      .SIDE_W (SA_W)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (s7_v_ff),
      .in_num_x     (s7_numx_ff),
      .in_num_y     (s7_numy_ff),
      .in_den       (s7_dmag_ff),
      .in_side      (s7_side_ff),
      .out_valid    (dv_v),
      .out_quo_x    (dv_qx),
      .out_quo_y    (dv_qy),
      .out_rem_nz_x (dv_rnzx),
      .out_rem_nz_y (dv_rnzy),
      .out_side     (dv_side)
   );

   assign dv_sa = side_a_type'(dv_side);

   // Fix-up 1: floored signed quotient, unbounded offsets pinned at 2^50
   logic [QEW-1:0] f1_qex, f1_qey;
   logic [QSW-1:0] f1_qtx, f1_qty, f1_qsx_in, f1_qsy_in;
   logic           f1_hugex, f1_hugey;

   always_comb begin
      f1_qex   = QEW'(dv_qx);
      f1_qey   = QEW'(dv_qy);
      f1_hugex = |f1_qex[QEW-1:HUGE_EXP];
      f1_hugey = |f1_qey[QEW-1:HUGE_EXP];
      f1_qtx   = QSW'(f1_qex);
      f1_qty   = QSW'(f1_qey);
      if (f1_hugex) begin
         f1_qsx_in = dv_sa.negx ? HUGE_NEG : HUGE_POS;
      end else begin
         f1_qsx_in = dv_sa.negx ? ~f1_qtx + QSW'(!dv_rnzx) : f1_qtx;
      end
      if (f1_hugey) begin
         f1_qsy_in = dv_sa.negy ? HUGE_NEG : HUGE_POS;
      end else begin
         f1_qsy_in = dv_sa.negy ? ~f1_qty + QSW'(!dv_rnzy) : f1_qty;
      end
   end

   logic                  d1_v_ff;
   logic signed [QSW-1:0] d1_qsx_ff, d1_qsy_ff;
   logic                  d1_huge_ff;
   side_a_type            d1_sa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff <= 1'b0;
      end else if (adv) begin
         d1_v_ff <= dv_v;
      end
      if (adv) begin
         d1_qsx_ff  <= f1_qsx_in;
         d1_qsy_ff  <= f1_qsy_in;
         d1_huge_ff <= f1_hugex || f1_hugey;
         d1_sa_ff   <= dv_sa;
      end
   end

   // Fix-up 2: centre, offset magnitudes, radius limit check
   logic signed [CW-1:0]  f2_ccx, f2_ccy, f2_cenx_in, f2_ceny_in;
   logic signed [QSW-1:0] f2_magx, f2_magy;
   logic                  f2_big_in;

   always_comb begin
      f2_ccx  = CW'(d1_sa_ff.ccx) <<< FRAC_BITS;
      f2_ccy  = CW'(d1_sa_ff.ccy) <<< FRAC_BITS;
      f2_magx = d1_qsx_ff[QSW-1] ? -d1_qsx_ff : d1_qsx_ff;
      f2_magy = d1_qsy_ff[QSW-1] ? -d1_qsy_ff : d1_qsy_ff;
      if (d1_sa_ff.col) begin
         f2_cenx_in = f2_ccx >>> 1;
         f2_ceny_in = f2_ccy >>> 1;
      end else begin
         f2_cenx_in = (CW'(d1_sa_ff.x1) <<< FRAC_BITS) + CW'(d1_qsx_ff);
         f2_ceny_in = (CW'(d1_sa_ff.y1) <<< FRAC_BITS) + CW'(d1_qsy_ff);
      end
      f2_big_in = d1_huge_ff || (|f2_magx[QSW-1:RAD_LIM_EXP])
                  || (|f2_magy[QSW-1:RAD_LIM_EXP]);
   end

   logic                   d2_v_ff;
   logic [RAD_LIM_EXP-1:0] d2_mx_ff, d2_my_ff;
   logic                   d2_big_ff, d2_col_ff;
   logic signed [CW-1:0]   d2_cenx_ff, d2_ceny_ff;
   logic [SUMW-1:0]        d2_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff <= 1'b0;
      end else if (adv) begin
         d2_v_ff <= d1_v_ff;
      end
      if (adv) begin
         d2_mx_ff   <= f2_magx[RAD_LIM_EXP-1:0];
         d2_my_ff   <= f2_magy[RAD_LIM_EXP-1:0];
         d2_big_ff  <= f2_big_in;
         d2_col_ff  <= d1_sa_ff.col;
         d2_cenx_ff <= f2_cenx_in;
         d2_ceny_ff <= f2_ceny_in;
         d2_dd_ff   <= d1_sa_ff.dd;
      end
   end

   // Squares of the offsets: partial products on half words
   logic                 d3_v_ff;
   logic [2*HW-1:0]      d3_hhx_ff, d3_hlx_ff, d3_llx_ff, d3_hhy_ff, d3_hly_ff, d3_lly_ff;
   logic                 d3_big_ff, d3_col_ff;
   logic signed [CW-1:0] d3_cenx_ff, d3_ceny_ff;
   logic [SUMW-1:0]      d3_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d3_v_ff <= 1'b0;
      end else if (adv) begin
         d3_v_ff <= d2_v_ff;
      end
      if (adv) begin
         d3_hhx_ff  <= d2_mx_ff[2*HW-1:HW] * d2_mx_ff[2*HW-1:HW];
         d3_hlx_ff  <= d2_mx_ff[2*HW-1:HW] * d2_mx_ff[HW-1:0];
         d3_llx_ff  <= d2_mx_ff[HW-1:0] * d2_mx_ff[HW-1:0];
         d3_hhy_ff  <= d2_my_ff[2*HW-1:HW] * d2_my_ff[2*HW-1:HW];
         d3_hly_ff  <= d2_my_ff[2*HW-1:HW] * d2_my_ff[HW-1:0];
         d3_lly_ff  <= d2_my_ff[HW-1:0] * d2_my_ff[HW-1:0];
         d3_big_ff  <= d2_big_ff;
         d3_col_ff  <= d2_col_ff;
         d3_cenx_ff <= d2_cenx_ff;
         d3_ceny_ff <= d2_ceny_ff;
         d3_dd_ff   <= d2_dd_ff;
      end
   end

   // Recombine partial products
   logic                 d4_v_ff;
   logic [SVW-1:0]       d4_sqx_ff, d4_sqy_ff;
   logic                 d4_big_ff, d4_col_ff;
   logic signed [CW-1:0] d4_cenx_ff, d4_ceny_ff;
   logic [SUMW-1:0]      d4_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d4_v_ff <= 1'b0;
      end else if (adv) begin
         d4_v_ff <= d3_v_ff;
      end
      if (adv) begin
         d4_sqx_ff  <= (SVW'(d3_hhx_ff) << (2 * HW)) + (SVW'(d3_hlx_ff) << (HW + 1))
                       + SVW'(d3_llx_ff);
         d4_sqy_ff  <= (SVW'(d3_hhy_ff) << (2 * HW)) + (SVW'(d3_hly_ff) << (HW + 1))
                       + SVW'(d3_lly_ff);
         d4_big_ff  <= d3_big_ff;
         d4_col_ff  <= d3_col_ff;
         d4_cenx_ff <= d3_cenx_ff;
         d4_ceny_ff <= d3_ceny_ff;
         d4_dd_ff   <= d3_dd_ff;
      end
   end

   // Square root operand: squared radius, or scaled squared diameter
   logic           d5_v_ff;
   logic [SVW-1:0] d5_sv_ff;
   side_b_type     d5_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d5_v_ff <= 1'b0;
      end else if (adv) begin
         d5_v_ff <= d4_v_ff;
      end
      if (adv) begin
         d5_sv_ff      <= d4_col_ff ? SVW'(d4_dd_ff) << (2 * FRAC_BITS)
                                    : d4_sqx_ff + d4_sqy_ff;
         d5_sb_ff.col  <= d4_col_ff;
         d5_sb_ff.big  <= d4_big_ff;
         d5_sb_ff.cenx <= d4_cenx_ff;
         d5_sb_ff.ceny <= d4_ceny_ff;
      end
   end

   // Square root
   logic            sq_v;
   logic [RTW-1:0]  sq_root;
   logic [SB_W-1:0] sq_side;
   side_b_type      sq_sb;

   ccirc_sqrt #(
      .VAL_W  (SVW),
      .SIDE_W (SB_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d5_v_ff),
      .in_value  (d5_sv_ff),
      .in_side   (d5_sb_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign sq_sb = side_b_type'(sq_side);

   // Clamp to output ranges
   logic           ov_x, ov_y, ov_r;
   logic [RTW-1:0] rad_full;

   always_comb begin
      ov_x = sq_sb.cenx[CW-1:OUT_BITS-1] != {(CW-OUT_BITS+1){sq_sb.cenx[CW-1]}};
      ov_y = sq_sb.ceny[CW-1:OUT_BITS-1] != {(CW-OUT_BITS+1){sq_sb.ceny[CW-1]}};
      if (sq_sb.col) begin
         rad_full = sq_root >> 1;
      end else if (sq_sb.big) begin
         rad_full = RAD_LIM;
      end else begin
         rad_full = sq_root;
      end
      ov_r = |rad_full[RTW-1:RAD_BITS];
      rsp_data_in.centre_x  = ov_x ? (sq_sb.cenx[CW-1] ? OUT_MIN : OUT_MAX)
                                   : sq_sb.cenx[OUT_BITS-1:0];
      rsp_data_in.centre_y  = ov_y ? (sq_sb.ceny[CW-1] ? OUT_MIN : OUT_MAX)
                                   : sq_sb.ceny[OUT_BITS-1:0];
      rsp_data_in.radius    = ov_r ? RAD_MAX : rad_full[RAD_BITS-1:0];
      rsp_data_in.collinear = sq_sb.col;
      rsp_data_in.saturated = ov_x || ov_y || ov_r;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_v;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Diameter circles always fit the output ranges
   a_col_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.collinear |-> !rsp_data.saturated)
      else $error("collinear result saturated");

   // A held response freezes the pipeline entry
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(s1_v_ff))
      else $error("pipeline moved during stall");

endmodule

// File: tb/circumcircle_checker.sv
// Channel monitor, circle predictor and result comparison for the circumcircle block.
`timescale 1ns / 1ps
module circumcircle_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  ccirc_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  ccirc_pkg::rsp_type rsp_data,
   output int                 error_count,
   output int                 circles_waiting,
   output int                 circles_checked,
   output int                 collinear_seen,
   output int                 saturated_seen
);
   import ccirc_pkg::*;

   localparam int F = FRAC_BITS_DEF;
   localparam longint CLAMP_HI = 64'sd549755813887;
   localparam longint CLAMP_LO = -64'sd549755813888;
   localparam longint HUGE_OFFSET = 64'sd1 << HUGE_EXP;
   localparam longint RAD_LIMIT = 64'sd1 << RAD_LIM_EXP;

   typedef logic signed [127:0] wint;

   rsp_type circle_queue[$];

   // Floor of the integer square root of a value below 2^128
   function automatic logic [127:0] floor_sqrt(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // floor(n * 2^F / d); an offset of 2^50 or more is marked unbounded
   function automatic longint scaled_quotient(wint n, wint d, inout bit unbounded);
      wint mn;
      wint md;
      wint q;
      wint r;
      bit neg;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = (mn <<< F) / md;
      r = (mn <<< F) % md;
      if (q >= wint'(HUGE_OFFSET)) begin
         unbounded = 1'b1;
         return neg ? -HUGE_OFFSET : HUGE_OFFSET;
      end
      if (neg) return -(longint'(q) + ((r != 0) ? 1 : 0));
      return longint'(q);
   endfunction

   // Expected circle for one point triple
   function automatic rsp_type circle_of(req_type t);
      longint x1, y1, x2, y2, x3, y3;
      longint ax, ay, bx, by, det2;
      longint d12, d13, d23, dd, ux, uy, vx, vy;
      longint cx, cy, qx, qy, mx, my;
      wint a2, b2, nx, ny;
      logic [127:0] rad;
      bit unbounded, sat, col;
      rsp_type res;
      x1 = longint'(t.first_x);  y1 = longint'(t.first_y);
      x2 = longint'(t.second_x); y2 = longint'(t.second_y);
      x3 = longint'(t.third_x);  y3 = longint'(t.third_y);
      ax = x2 - x1; ay = y2 - y1; bx = x3 - x1; by = y3 - y1;
      det2 = 2 * (ax * by - ay * bx);
      unbounded = 0; sat = 0; col = 0;
      if (det2 == 0) begin
         // degenerate: diameter circle of the farthest pair, ties to earlier pair
         col = 1;
         d12 = (x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1);
         d13 = (x3 - x1) * (x3 - x1) + (y3 - y1) * (y3 - y1);
         d23 = (x3 - x2) * (x3 - x2) + (y3 - y2) * (y3 - y2);
         ux = x1; uy = y1; vx = x2; vy = y2; dd = d12;
         if (!(d12 >= d13 && d12 >= d23)) begin
            if (d13 >= d23) begin
               vx = x3; vy = y3; dd = d13;
            end else begin
               ux = x2; uy = y2; vx = x3; vy = y3; dd = d23;
            end
         end
         cx = ((ux + vx) * (64'sd1 <<< F)) >>> 1;
         cy = ((uy + vy) * (64'sd1 <<< F)) >>> 1;
         rad = floor_sqrt(128'(dd) << (2 * F)) >> 1;
      end else begin
         a2 = wint'(ax * ax + ay * ay);
         b2 = wint'(bx * bx + by * by);
         nx = wint'(by) * a2 - wint'(ay) * b2;
         ny = wint'(ax) * b2 - wint'(bx) * a2;
         qx = scaled_quotient(nx, wint'(det2), unbounded);
         qy = scaled_quotient(ny, wint'(det2), unbounded);
         mx = (qx < 0) ? -qx : qx;
         my = (qy < 0) ? -qy : qy;
         cx = x1 * (64'sd1 <<< F) + qx;
         cy = y1 * (64'sd1 <<< F) + qy;
         if (unbounded || mx >= RAD_LIMIT || my >= RAD_LIMIT)
            rad = 128'(RAD_LIMIT);
         else
            rad = floor_sqrt(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
      end
      // clip to the output ranges
      if (cx > CLAMP_HI) begin cx = CLAMP_HI; sat = 1; end
      if (cx < CLAMP_LO) begin cx = CLAMP_LO; sat = 1; end
      if (cy > CLAMP_HI) begin cy = CLAMP_HI; sat = 1; end
      if (cy < CLAMP_LO) begin cy = CLAMP_LO; sat = 1; end
      if (rad > 128'(RAD_MAX)) begin rad = 128'(RAD_MAX); sat = 1; end
      res.centre_x  = cx[OUT_BITS-1:0];
      res.centre_y  = cy[OUT_BITS-1:0];
      res.radius    = rad[RAD_BITS-1:0];
      res.collinear = col;
      res.saturated = sat;
      return res;
   endfunction

   assign circles_waiting = circle_queue.size();

   // Predict on every accepted request, compare on every accepted response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         error_count <= 0;
         circles_checked <= 0;
         collinear_seen <= 0;
         saturated_seen <= 0;
      end else begin
         if (req_valid && !req_stall) circle_queue = {circle_queue, circle_of(req_data)};
         if (rsp_valid && !rsp_stall) begin
            if (circle_queue.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count <= error_count + 1;
            end else begin
               want = circle_queue.pop_front();
               circles_checked <= circles_checked + 1;
               collinear_seen <= collinear_seen + want.collinear;
               saturated_seen <= saturated_seen + want.saturated;
               if (rsp_data !== want) error_count <= error_count + 1;
               if (rsp_data.centre_x !== want.centre_x)
                  $error("centre_x expected %0d got %0d", want.centre_x, rsp_data.centre_x);
               if (rsp_data.centre_y !== want.centre_y)
                  $error("centre_y expected %0d got %0d", want.centre_y, rsp_data.centre_y);
               if (rsp_data.radius !== want.radius)
                  $error("radius expected %0d got %0d", want.radius, rsp_data.radius);
               if (rsp_data.collinear !== want.collinear)
                  $error("collinear expected %0b got %0b", want.collinear, rsp_data.collinear);
               if (rsp_data.saturated !== want.saturated)
                  $error("saturated expected %0b got %0b", want.saturated, rsp_data.saturated);
            end
         end
      end
   end

endmodule

// File: tb/circumcircle_of_three_points_tb.sv
// Top of the circumcircle testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module circumcircle_of_three_points_tb;
   import ccirc_pkg::*;

   localparam int RANDOM_TRIPLES = 1800;
   localparam int QUIET_TAIL     = 300;
   localparam int DRAIN_CYCLES   = 150;
   localparam int CYCLE_LIMIT    = 500000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   int  error_count, circles_waiting, circles_checked, collinear_seen, saturated_seen;
   int  cycle_count = 0;
   int  triples_sent = 0;
   bit  quiet = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   circumcircle_of_three_points DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   circumcircle_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .error_count(error_count), .circles_waiting(circles_waiting),
      .circles_checked(circles_checked), .collinear_seen(collinear_seen),
      .saturated_seen(saturated_seen)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Result-side backpressure in random bursts
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic req_type triple(int x1, int y1, int x2, int y2, int x3, int y3);
      req_type t;
      t.first_x = COORD_BITS'(x1);  t.first_y = COORD_BITS'(y1);
      t.second_x = COORD_BITS'(x2); t.second_y = COORD_BITS'(y2);
      t.third_x = COORD_BITS'(x3);  t.third_y = COORD_BITS'(y3);
      return t;
   endfunction

   function automatic int coord_of(int lo, int hi);
      return int'($urandom_range(hi - lo, 0)) + lo;
   endfunction

   // One request transaction, then maybe a gap
   task automatic send_triple(req_type t);
      req_valid <= 1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      triples_sent++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Random triple from one of several shapes
   function automatic req_type random_triple();
      int x1, y1, dx, dy, k, m, lim;
      int pick;
      pick = $urandom_range(0, 9);
      lim = ($urandom_range(0, 1) == 1) ? 32767 : 200;
      x1 = coord_of(-lim - 1, lim);
      y1 = coord_of(-lim - 1, lim);
      case (pick)
         0, 1, 2: begin
            return triple(coord_of(-32768, 32767), coord_of(-32768, 32767),
                          coord_of(-32768, 32767), coord_of(-32768, 32767),
                          coord_of(-32768, 32767), coord_of(-32768, 32767));
         end
         3, 4: begin
            return triple(x1, y1, coord_of(-lim - 1, lim), coord_of(-lim - 1, lim),
                          coord_of(-lim - 1, lim), coord_of(-lim - 1, lim));
         end
         5, 6: begin
            // collinear: points on a small-step line through the first point
            x1 = coord_of(-1000, 1000); y1 = coord_of(-1000, 1000);
            dx = coord_of(-30, 30); dy = coord_of(-30, 30);
            k = coord_of(-20, 20); m = coord_of(-20, 20);
            return triple(x1, y1, x1 + k * dx, y1 + k * dy, x1 + m * dx, y1 + m * dy);
         end
         7: begin
            // repeated points in some arrangement
            dx = coord_of(-32768, 32767); dy = coord_of(-32768, 32767);
            case ($urandom_range(0, 3))
               0: return triple(x1, y1, x1, y1, dx, dy);
               1: return triple(x1, y1, dx, dy, x1, y1);
               2: return triple(dx, dy, x1, y1, x1, y1);
               default: return triple(x1, y1, x1, y1, x1, y1);
            endcase
         end
         default: begin
            // nearly degenerate: third point within one step of the second, far end of a long line
            x1 = coord_of(-32768, -20000); y1 = coord_of(-32768, 32767);
            dx = coord_of(20000, 32767);
            dy = coord_of(-32768, 32767);
            return triple(x1, y1, dx, dy, dx + coord_of(-1, 1), dy + coord_of(-1, 1));
         end
      endcase
   endfunction

   initial begin
      req_type directed[$];
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed corners
      directed = {directed, triple(0, 0, 0, 0, 0, 0)};
      directed = {directed, triple(-32768, -32768, -32768, -32768, -32768, -32768)};
      directed = {directed, triple(32767, 32767, 32767, 32767, 32767, 32767)};
      directed = {directed, triple(0, 0, 4, 0, 0, 3)};
      directed = {directed, triple(1, 1, 2, 5, -7, 3)};
      directed = {directed, triple(-32768, -32768, 32767, -32768, -32768, 32767)};
      directed = {directed, triple(32767, 32767, -32768, 32767, 32767, -32768)};
      directed = {directed, triple(-32768, 32767, 32767, -32768, 32767, 32767)};
      directed = {directed, triple(0, 0, 10, 0, 5, 0)};
      directed = {directed, triple(0, 0, 5, 0, 10, 0)};
      directed = {directed, triple(5, 0, 0, 0, 10, 0)};
      directed = {directed, triple(-1, 0, 1, 0, 1, 0)};
      directed = {directed, triple(0, 0, 3, 3, -3, -3)};
      directed = {directed, triple(-32768, -32768, 32767, 32767, 0, 0)};
      directed = {directed, triple(-32768, 0, 32767, 0, -32768, 0)};
      directed = {directed, triple(7, -9, 7, -9, 100, 200)};
      directed = {directed, triple(-32768, -32768, 32767, 32767, 32767, 32766)};
      directed = {directed, triple(-32768, -32767, 32767, 32767, 32766, 32766)};
      directed = {directed, triple(32767, -32768, -32768, 32767, -32767, 32767)};
      directed = {directed, triple(1, 0, 0, 1, -1, 0)};
      directed = {directed, triple(-3, -3, -2, -2, -1, -2)};
      directed = {directed, triple(0, 0, 1, 0, 0, 1)};
      foreach (directed[i]) send_triple(directed[i]);

      // Random triples; the tail runs with no gaps and no backpressure
      for (int i = 0; i < RANDOM_TRIPLES; i++) begin
         if (i == RANDOM_TRIPLES - QUIET_TAIL) quiet = 1;
         send_triple(random_triple());
      end
      req_valid <= 0;

      while (circles_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d triples, checked %0d circles", triples_sent, circles_checked);
      $display("%0d collinear or repeated, %0d clipped", collinear_seen, saturated_seen);
      if (error_count == 0 && circles_waiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
src/ccirc_pkg.sv
src/ccirc_div.sv
src/ccirc_sqrt.sv
src/circumcircle_of_three_points.sv
tb/circumcircle_checker.sv
tb/circumcircle_of_three_points_tb.sv
